>>> hw/rtl/bzf_pkg.sv
package bzf_pkg;

    // Default width of the coordinates that the datapath actually uses.
    localparam int COORD_BITS_DEF = 32;

    // Reset values of the configuration registers.
    localparam logic [31:0] FLAT_THRESHOLD_RST = 32'd256;
    localparam logic [4:0]  FRAC_BITS_RST      = 5'd16;

    // Points emitted for one split segment.
    localparam int MAX_PTS = 4;
    localparam int PT_IDX_W = $clog2(MAX_PTS);

    // Operation codes of an input word.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FLAT_THRESHOLD = 1'b0,
        CFG_FRAC_BITS      = 1'b1
    } cfg_idx_t;

    // Input word.
    typedef struct packed {
        logic               op;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               is_end_point;
        logic               last_of_run;
        logic        [31:0] max_unflat;
    } out_word_t;

    // One emitted point at output width.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pt_t;

    // Control handed to the output buffer with a finished segment.
    typedef struct packed {
        logic        split;
        logic [31:0] max_unflat;
    } emit_load_t;

endpackage

>>> hw/rtl/bzf_emit.sv
module bzf_emit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load_valid,
    input  bzf_pkg::emit_load_t                     load,
    input  bzf_pkg::pt_t [bzf_pkg::MAX_PTS-1:0]     pts,
    output logic                                    free,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output bzf_pkg::out_word_t                      out_data
);
    import bzf_pkg::*;

    logic                  valid_reg;
    logic                  split_reg;
    logic [31:0]           max_reg;
    logic [PT_IDX_W-1:0]   idx_reg;
    pt_t  [MAX_PTS-1:0]    pts_reg;
    logic                  last;
    logic                  take;

    // A flat segment ends after its second point, a split one after its fourth.
    assign last = split_reg ? (idx_reg == PT_IDX_W'(MAX_PTS - 1)) : (idx_reg == PT_IDX_W'(1));
    assign take = valid_reg && out_ready;
    assign free = !valid_reg || (out_ready && last);

    // Buffer control: load a new segment or step through the stored points.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load_valid)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + PT_IDX_W'(1);
        end
    end

    // Segment payload.
    always_ff @(posedge clk)
    begin
        if (load_valid)
        begin
            split_reg <= load.split;
            max_reg   <= load.max_unflat;
            pts_reg   <= pts;
        end
    end

    // Output word, read straight from the buffer.
    assign out_valid             = valid_reg;
    assign out_data.out_x        = pts_reg[idx_reg].x;
    assign out_data.out_y        = pts_reg[idx_reg].y;
    assign out_data.is_end_point = idx_reg[0];
    assign out_data.last_of_run  = last;
    assign out_data.max_unflat   = max_reg;

    // A flat segment never walks past its second point.
    a_flat_idx: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !split_reg |-> idx_reg <= PT_IDX_W'(1))
        else $error("flat segment index out of range");

    // Taking the final point with nothing loaded empties the buffer.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && last && !load_valid |=> !valid_reg)
        else $error("buffer did not drain after final point");

endmodule

>>> hw/rtl/bezier2_flatten_step.sv
// Quadratic Bezier flattening step. Start words (op 0) set the curve start and
// clear the running maximum; segment words (op 1) give a control and end point.
// Each segment is measured for unflatness and emitted either as its own two
// points or, if split at t=1/2, as four points, one result word per cycle
// while out_ready is high. A word passes four pipeline registers (accepted
// word, midpoints, deviations, squares). Unflatness and the split decision
// are worked out on the way into the output buffer. The sustained rate is set
// by the output buffer, which sends one point per cycle while out_ready is
// high: two points per flat segment and four per split segment. A start word
// sends nothing and leaves the last stage without waiting for the buffer, so
// it overlaps with points still being sent. Configuration is always
// ready and is read at the decision stage, so it applies to every word that
// reaches that stage after the write; write it only while no word is in flight.
module bezier2_flatten_step #(
    parameter int COORD_BITS = bzf_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bzf_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bzf_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bzf_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data
);
    import bzf_pkg::*;

    localparam int CW = COORD_BITS;

    typedef logic signed [CW-1:0] crd_t;
    typedef logic [CW:0]          mag_t;

    // floor((a + b) / 2), exact.
    function automatic crd_t avg(input crd_t a, input crd_t b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    // Magnitude of a difference b - c.
    function automatic mag_t abs_diff(input crd_t b, input crd_t c);
        logic signed [CW:0] d;
        d = {b[CW-1], b} - {c[CW-1], c};
        return d[CW] ? mag_t'(-d) : mag_t'(d);
    endfunction

    // Deviation of the middle point from the curve midpoint.
    function automatic mag_t dev3(input crd_t a, input crd_t b, input crd_t c);
        return abs_diff(b, avg(avg(a, b), avg(b, c)));
    endfunction

    // Shift and saturate the sum of squares.
    function automatic logic [31:0] unflat_fin(input logic [63:0] sqx,
                                               input logic [63:0] sqy,
                                               input logic        sat,
                                               input logic [4:0]  sh);
        logic [64:0] s;
        logic [64:0] t;
        s = {1'b0, sqx} + {1'b0, sqy};
        t = s >> sh;
        return (sat || (|t[64:32])) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    // Configuration registers.
    logic [31:0] flat_threshold_reg;
    logic [4:0]  frac_bits_reg;

    // Curve state.
    crd_t        prev_end_reg [2];
    logic [31:0] running_max_reg;
    logic [31:0] running_max_next;

    // Pipeline registers.
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    crd_t        s1_p0_reg [2], s1_a_reg [2], s1_e_reg [2];
    crd_t        s2_p0_reg [2], s2_a_reg [2], s2_e_reg [2];
    crd_t        s2_y1_reg [2], s2_z1_reg [2], s2_y2_reg [2];
    crd_t        s3_a_reg [2], s3_e_reg [2], s3_y1_reg [2], s3_z1_reg [2], s3_y2_reg [2];
    crd_t        s4_a_reg [2], s4_e_reg [2], s4_y1_reg [2], s4_z1_reg [2], s4_y2_reg [2];
    logic [32:0] s3_mag_reg [3][2];
    logic [63:0] s4_sq_reg [3][2];
    logic        s4_sat_reg [3];

    logic        en1, en2, en3, en4, adv4;
    logic        in_take;
    crd_t        in_a [2], in_e [2];

    logic [31:0] u0, u1, u2, u12, cand;
    logic        split;

    logic                 emit_free;
    logic                 emit_load_valid;
    emit_load_t           emit_load;
    pt_t [MAX_PTS-1:0]    emit_pts;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_threshold_reg <= FLAT_THRESHOLD_RST;
            frac_bits_reg      <= FRAC_BITS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLAT_THRESHOLD: flat_threshold_reg <= cfg_data;
                CFG_FRAC_BITS:      frac_bits_reg      <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // Pipeline advance; a start word leaves the last stage without the buffer.
    assign adv4     = s4_valid_reg && (s4_op_reg == OP_START || emit_free);
    assign en4      = !s4_valid_reg || adv4;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign in_take  = in_valid && en1;

    // Only the low coordinate bits are used.
    assign in_a[0] = in_data.point_a_x[CW-1:0];
    assign in_a[1] = in_data.point_a_y[CW-1:0];
    assign in_e[0] = in_data.end_x[CW-1:0];
    assign in_e[1] = in_data.end_y[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // The start of each segment is the previous end, tracked at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg[0] <= '0;
            prev_end_reg[1] <= '0;
        end
        else if (in_take)
        begin
            for (int c = 0; c < 2; c++)
            begin
                prev_end_reg[c] <= (in_data.op == OP_START) ? in_a[c] : in_e[c];
            end
        end
    end

    // Stage 1: accepted word.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg <= in_data.op;
            for (int c = 0; c < 2; c++)
            begin
                s1_p0_reg[c] <= prev_end_reg[c];
                s1_a_reg[c]  <= in_a[c];
                s1_e_reg[c]  <= in_e[c];
            end
        end
    end

    // Stage 2: de Casteljau midpoints.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg <= s1_op_reg;
            for (int c = 0; c < 2; c++)
            begin
                s2_p0_reg[c] <= s1_p0_reg[c];
                s2_a_reg[c]  <= s1_a_reg[c];
                s2_e_reg[c]  <= s1_e_reg[c];
                s2_y1_reg[c] <= avg(s1_p0_reg[c], s1_a_reg[c]);
                s2_z1_reg[c] <= avg(s1_a_reg[c], s1_e_reg[c]);
                s2_y2_reg[c] <= avg(avg(s1_p0_reg[c], s1_a_reg[c]),
                                    avg(s1_a_reg[c], s1_e_reg[c]));
            end
        end
    end

    // Stage 3: deviations of the whole segment and of both halves.
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_op_reg <= s2_op_reg;
            for (int c = 0; c < 2; c++)
            begin
                s3_a_reg[c]      <= s2_a_reg[c];
                s3_e_reg[c]      <= s2_e_reg[c];
                s3_y1_reg[c]     <= s2_y1_reg[c];
                s3_z1_reg[c]     <= s2_z1_reg[c];
                s3_y2_reg[c]     <= s2_y2_reg[c];
                s3_mag_reg[0][c] <= 33'(abs_diff(s2_a_reg[c], s2_y2_reg[c]));
                s3_mag_reg[1][c] <= 33'(dev3(s2_p0_reg[c], s2_y1_reg[c], s2_y2_reg[c]));
                s3_mag_reg[2][c] <= 33'(dev3(s2_y2_reg[c], s2_z1_reg[c], s2_e_reg[c]));
            end
        end
    end

    // Stage 4: squares; a deviation of 2^32 or more saturates.
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_op_reg <= s3_op_reg;
            for (int c = 0; c < 2; c++)
            begin
                s4_a_reg[c]  <= s3_a_reg[c];
                s4_e_reg[c]  <= s3_e_reg[c];
                s4_y1_reg[c] <= s3_y1_reg[c];
                s4_z1_reg[c] <= s3_z1_reg[c];
                s4_y2_reg[c] <= s3_y2_reg[c];
            end
            for (int k = 0; k < 3; k++)
            begin
                s4_sat_reg[k] <= s3_mag_reg[k][0][32] || s3_mag_reg[k][1][32];
                for (int c = 0; c < 2; c++)
                begin
                    s4_sq_reg[k][c] <= {32'd0, s3_mag_reg[k][c][31:0]}
                                     * {32'd0, s3_mag_reg[k][c][31:0]};
                end
            end
        end
    end

    // Unflatness, split decision and running maximum.
    always_comb
    begin
        u0    = unflat_fin(s4_sq_reg[0][0], s4_sq_reg[0][1], s4_sat_reg[0], frac_bits_reg);
        u1    = unflat_fin(s4_sq_reg[1][0], s4_sq_reg[1][1], s4_sat_reg[1], frac_bits_reg);
        u2    = unflat_fin(s4_sq_reg[2][0], s4_sq_reg[2][1], s4_sat_reg[2], frac_bits_reg);
        u12   = (u1 > u2) ? u1 : u2;
        split = u0 > flat_threshold_reg;
        cand  = split ? u12 : u0;
        if (s4_op_reg == OP_START)
        begin
            running_max_next = '0;
        end
        else
        begin
            running_max_next = (cand > running_max_reg) ? cand : running_max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_max_reg <= '0;
        end
        else if (adv4)
        begin
            running_max_reg <= running_max_next;
        end
    end

    // Points handed to the output buffer.
    always_comb
    begin
        emit_pts[0].x = split ? 32'(s4_y1_reg[0]) : 32'(s4_a_reg[0]);
        emit_pts[0].y = split ? 32'(s4_y1_reg[1]) : 32'(s4_a_reg[1]);
        emit_pts[1].x = split ? 32'(s4_y2_reg[0]) : 32'(s4_e_reg[0]);
        emit_pts[1].y = split ? 32'(s4_y2_reg[1]) : 32'(s4_e_reg[1]);
        emit_pts[2].x = 32'(s4_z1_reg[0]);
        emit_pts[2].y = 32'(s4_z1_reg[1]);
        emit_pts[3].x = 32'(s4_e_reg[0]);
        emit_pts[3].y = 32'(s4_e_reg[1]);
    end

    assign emit_load_valid      = adv4 && (s4_op_reg == OP_SEGMENT);
    assign emit_load.split      = split;
    assign emit_load.max_unflat = running_max_next;

    bzf_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (emit_load_valid),
        .load       (emit_load),
        .pts        (emit_pts),
        .free       (emit_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Within a curve the running maximum only grows.
    a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        adv4 && s4_op_reg == OP_SEGMENT |=> running_max_reg >= $past(running_max_reg))
        else $error("running maximum decreased within a curve");

    // A start word clears the running maximum.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv4 && s4_op_reg == OP_START |=> running_max_reg == 32'd0)
        else $error("start word did not clear running maximum");

endmodule
